@@ rtl/tber_pkg.sv @@
// ----------------------------------------------------------------------------
// tber_pkg: shared types and constants for the trace begin/end repair block
// Holds the stack size, the result status codes, the controller states and
// the command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package tber_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FN_W        = 16;
  localparam int TICK_W      = 64;
  localparam int GAP_W       = 16;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [GAP_W-1:0] GAP_RESET = 16'd100;

  typedef enum logic [0:0] {
    ACT_EVENT  = 1'b0,
    ACT_FINISH = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    KIND_BEGIN = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_KEPT          = 3'd0,
    ST_BEGIN_DROPPED = 3'd1,
    ST_ORPHAN_DROP   = 3'd2,
    ST_INSERTED      = 3'd3,
    ST_NOTHING_OPEN  = 3'd4,
    ST_OVERFLOW      = 3'd5
  } status_t;

  typedef enum logic [0:0] {
    REG_GAP = 1'b0
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_OUT,
    S_FPOP,
    S_FLOAD,
    S_FOUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fin_pop;
    logic fin_load;
    logic fin_adv;
  } cmd_t;

  typedef struct packed {
    logic is_finish;
    logic open_empty;
  } dp_sts_t;

endpackage

@@ rtl/tber_in_if.sv @@
// ----------------------------------------------------------------------------
// tber_in_if: input request channel
// Carries one profiler event or a finish request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tber_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        event_kind;
  logic [15:0] function_index;
  logic [63:0] event_tick;

  modport source (output valid, output action, output event_kind,
                  output function_index, output event_tick, input ready);
  modport sink (input valid, input action, input event_kind,
                input function_index, input event_tick, output ready);
endinterface

@@ rtl/tber_out_if.sv @@
// ----------------------------------------------------------------------------
// tber_out_if: result request channel
// Carries one kept, dropped or inserted event with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tber_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [15:0] out_function;
  logic [63:0] out_tick;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output out_kind, output out_function,
                  output out_tick, output status, output last, input ready);
  modport sink (input valid, input out_kind, input out_function,
                input out_tick, input status, input last, output ready);
endinterface

@@ rtl/trace_begin_end_repair.sv @@
// ----------------------------------------------------------------------------
// trace_begin_end_repair: profiler begin/end nesting repair
// Keeps, drops or closes begin/end events with an open stack and an orphan
// stack, and closes all open begins with inserted ends on a finish request.
//
//   Channel  Direction  Handshake              Contents
//   in_if    sink       valid/ready            action, kind, function, tick
//   out_if   source     valid/ready            kind, function, tick, status
//   APB      slave      psel/penable, pready   inserted end gap at 0x0
//
// An ordinary event, or a finish with nothing open, passes through the
// accepting state, an evaluation state on the captured request and the
// registered orphan stack top, and a state with the result valid.
// A finish with begins open passes the accepting and evaluation states, then
// for each open entry a pop with a registered read of the open stack, a
// result load and a state with the result valid.
// The next request is accepted the cycle after the last result is taken.
// A stalled result holds its value until it is taken.
// Reset clears the counts and the last kept tick and sets the gap to 100.
// ----------------------------------------------------------------------------
module trace_begin_end_repair (
  input  logic                          clk,
  input  logic                          rst_n,
  tber_in_if.sink                       in_if,
  tber_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tber_pkg::ADDR_W-1:0]   paddr,
  input  logic [tber_pkg::DATA_W-1:0]   pwdata,
  output logic [tber_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tber_pkg::*;

  cmd_t             cmd;
  dp_sts_t          sts;
  logic             gap_we;
  logic [GAP_W-1:0] gap;
  logic [2:0]       status;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_GAP);
  assign gap_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? DATA_W'(gap) : '0;

  tber_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tber_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_if.action),
    .in_event_kind     (in_if.event_kind),
    .in_function_index (in_if.function_index),
    .in_event_tick     (in_if.event_tick),
    .gap_we            (gap_we),
    .gap_wdata         (pwdata[GAP_W-1:0]),
    .gap               (gap),
    .out_kind          (out_if.out_kind),
    .out_function      (out_if.out_function),
    .out_tick          (out_if.out_tick),
    .out_status        (status),
    .out_last          (out_if.last)
  );

  assign out_if.status = status;

endmodule

@@ rtl/tber_ctrl.sv @@
// ----------------------------------------------------------------------------
// tber_ctrl: sequencing controller
// Accepts one request at a time, steps the datapath through evaluation or
// the finish walk, and runs the result handshake.
// ----------------------------------------------------------------------------
module tber_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  tber_pkg::dp_sts_t sts,
  output tber_pkg::cmd_t   cmd
);
  import tber_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_finish && !sts.open_empty) begin
          state_nxt = S_FPOP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      S_FPOP: begin
        cmd.fin_pop = 1'b1;
        state_nxt   = S_FLOAD;
      end
      S_FLOAD: begin
        cmd.fin_load = 1'b1;
        state_nxt    = S_FOUT;
      end
      S_FOUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.fin_adv = 1'b1;
          state_nxt   = sts.open_empty ? S_IDLE : S_FPOP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/tber_dp.sv @@
// ----------------------------------------------------------------------------
// tber_dp: stacks, counters and result register
// Holds the open and orphan stacks as memories with registered reads, the
// stack counts, the last kept tick, the gap register and the result fields.
// ----------------------------------------------------------------------------
module tber_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tber_pkg::cmd_t                cmd,
  output tber_pkg::dp_sts_t             sts,
  input  logic                          in_action,
  input  logic                          in_event_kind,
  input  logic [tber_pkg::FN_W-1:0]     in_function_index,
  input  logic [tber_pkg::TICK_W-1:0]   in_event_tick,
  input  logic                          gap_we,
  input  logic [tber_pkg::GAP_W-1:0]    gap_wdata,
  output logic [tber_pkg::GAP_W-1:0]    gap,
  output logic                          out_kind,
  output logic [tber_pkg::FN_W-1:0]     out_function,
  output logic [tber_pkg::TICK_W-1:0]   out_tick,
  output logic [2:0]                    out_status,
  output logic                          out_last
);
  import tber_pkg::*;

  logic [FN_W-1:0]   open_mem [STACK_DEPTH];
  logic [FN_W-1:0]   orph_mem [STACK_DEPTH];
  logic [FN_W-1:0]   open_rd_r;
  logic [FN_W-1:0]   orph_rd_r;

  logic [CNT_W-1:0]  open_cnt_r,  open_cnt_nxt;
  logic [CNT_W-1:0]  orph_cnt_r,  orph_cnt_nxt;
  logic [TICK_W-1:0] last_tick_r, last_tick_nxt;
  logic [TICK_W-1:0] fin_tick_r,  fin_tick_nxt;
  logic [GAP_W-1:0]  gap_r;

  logic              act_r;
  logic              kind_r;
  logic [FN_W-1:0]   fn_r;
  logic [TICK_W-1:0] tick_r;

  logic              out_kind_r,  out_kind_nxt;
  logic [FN_W-1:0]   out_fn_r,    out_fn_nxt;
  logic [TICK_W-1:0] out_tick_r,  out_tick_nxt;
  status_t           out_st_r,    out_st_nxt;
  logic              out_last_r,  out_last_nxt;
  logic              out_load;

  logic              open_push;
  logic              orph_push;
  logic [CNT_W-1:0]  open_top;
  logic [CNT_W-1:0]  orph_top;

  assign open_top = open_cnt_r - CNT_W'(1);
  assign orph_top = orph_cnt_r - CNT_W'(1);

  assign sts.is_finish  = act_r;
  assign sts.open_empty = (open_cnt_r == '0);

  always_comb begin
    open_cnt_nxt  = open_cnt_r;
    orph_cnt_nxt  = orph_cnt_r;
    last_tick_nxt = last_tick_r;
    fin_tick_nxt  = fin_tick_r;
    open_push     = 1'b0;
    orph_push     = 1'b0;
    out_load      = 1'b0;
    out_kind_nxt  = kind_r;
    out_fn_nxt    = fn_r;
    out_tick_nxt  = tick_r;
    out_st_nxt    = ST_KEPT;
    out_last_nxt  = 1'b1;
    if (cmd.exec) begin
      out_load = 1'b1;
      if (act_r == ACT_FINISH) begin
        fin_tick_nxt = last_tick_r;
        if (open_cnt_r == '0) begin
          out_kind_nxt  = 1'b0;
          out_fn_nxt    = '0;
          out_tick_nxt  = '0;
          out_st_nxt    = ST_NOTHING_OPEN;
          orph_cnt_nxt  = '0;
          last_tick_nxt = '0;
        end
      end else if (kind_r == KIND_BEGIN) begin
        if (orph_cnt_r != '0 && orph_rd_r == fn_r) begin
          orph_cnt_nxt = orph_top;
          out_st_nxt   = ST_BEGIN_DROPPED;
        end else if (open_cnt_r == CNT_W'(STACK_DEPTH)) begin
          out_st_nxt = ST_OVERFLOW;
        end else begin
          open_push     = 1'b1;
          open_cnt_nxt  = open_cnt_r + CNT_W'(1);
          last_tick_nxt = tick_r;
        end
      end else if (open_cnt_r == '0) begin
        if (orph_cnt_r == CNT_W'(STACK_DEPTH)) begin
          out_st_nxt = ST_OVERFLOW;
        end else begin
          orph_push    = 1'b1;
          orph_cnt_nxt = orph_cnt_r + CNT_W'(1);
          out_st_nxt   = ST_ORPHAN_DROP;
        end
      end else begin
        open_cnt_nxt  = open_top;
        last_tick_nxt = tick_r;
      end
    end
    if (cmd.fin_pop) begin
      open_cnt_nxt = open_top;
    end
    if (cmd.fin_load) begin
      out_load     = 1'b1;
      out_kind_nxt = KIND_END;
      out_fn_nxt   = open_rd_r;
      out_tick_nxt = fin_tick_r;
      out_st_nxt   = ST_INSERTED;
      out_last_nxt = (open_cnt_r == '0);
    end
    if (cmd.fin_adv) begin
      fin_tick_nxt = fin_tick_r + TICK_W'(gap_r);
      if (open_cnt_r == '0) begin
        orph_cnt_nxt  = '0;
        last_tick_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_cnt_r  <= '0;
      orph_cnt_r  <= '0;
      last_tick_r <= '0;
      gap_r       <= GAP_RESET;
    end else begin
      open_cnt_r  <= open_cnt_nxt;
      orph_cnt_r  <= orph_cnt_nxt;
      last_tick_r <= last_tick_nxt;
      if (gap_we) begin
        gap_r <= gap_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_tick_r <= fin_tick_nxt;
    if (cmd.capture) begin
      act_r  <= in_action;
      kind_r <= in_event_kind;
      fn_r   <= in_function_index;
      tick_r <= in_event_tick;
    end
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_fn_r   <= out_fn_nxt;
      out_tick_r <= out_tick_nxt;
      out_st_r   <= out_st_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (open_push) begin
      open_mem[open_cnt_r[IDX_W-1:0]] <= fn_r;
    end
    open_rd_r <= open_mem[open_top[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (orph_push) begin
      orph_mem[orph_cnt_r[IDX_W-1:0]] <= fn_r;
    end
    orph_rd_r <= orph_mem[orph_top[IDX_W-1:0]];
  end

  assign gap          = gap_r;
  assign out_kind     = out_kind_r;
  assign out_function = out_fn_r;
  assign out_tick     = out_tick_r;
  assign out_status   = out_st_r;
  assign out_last     = out_last_r;

endmodule

@@ rtl/tber_chk.sv @@
// ----------------------------------------------------------------------------
// tber_chk: port-level checks for the trace begin/end repair block
// Watches the request channels of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module tber_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_tick,
  input logic [2:0]  status,
  input logic        last
);
  import tber_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not busy after accepting a request");

  a_only_inserted_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> status == ST_INSERTED)
    else $error("non-final result that is not an inserted end");

  a_nothing_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_NOTHING_OPEN |-> last && out_tick == '0)
    else $error("nothing-open result malformed");

endmodule

bind trace_begin_end_repair tber_chk u_tber_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_tick  (out_if.out_tick),
  .status    (out_if.status),
  .last      (out_if.last)
);

@@ tb/sv/trace_repair_checker.sv @@
// ----------------------------------------------------------------------------
// trace_repair_checker: result checker for the trace begin/end repair block
// Watches the request, result and register channels. Each accepted request
// runs through a model of the open and orphan stacks, and the repaired events
// it should produce are queued. Each accepted result is compared field by
// field with the oldest queued event, and every mismatch is counted.
// ----------------------------------------------------------------------------
module trace_repair_checker
  import tber_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tber_in_if                in_ch,
  tber_out_if               out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                inserted_seen
);

  localparam logic [ADDR_W-1:0] GAP_ADDR  = ADDR_W'(4 * REG_GAP);

  typedef struct packed {
    kind_t             kind;
    logic [FN_W-1:0]   fn;
    logic [TICK_W-1:0] tick;
    status_t           status;
    logic              last;
  } repaired_t;

  repaired_t         repaired_q[$];
  repaired_t         oldest;
  logic [FN_W-1:0]   open_fns   [STACK_DEPTH];
  logic [FN_W-1:0]   orphan_fns [STACK_DEPTH];
  int                open_depth;
  int                orphan_depth;
  logic [TICK_W-1:0] last_tick;
  logic [GAP_W-1:0]  end_gap;

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [TICK_W-1:0] got, logic [TICK_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s is 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  function automatic void queue_result(kind_t kind, logic [FN_W-1:0] fn,
                                       logic [TICK_W-1:0] tick, status_t status,
                                       logic last);
    repaired_t r;
    r.kind   = kind;
    r.fn     = fn;
    r.tick   = tick;
    r.status = status;
    r.last   = last;
    repaired_q = {repaired_q, r};
  endfunction

  function automatic void repair_request(action_t act, kind_t kind, logic [FN_W-1:0] fn,
                                         logic [TICK_W-1:0] tick);
    logic [TICK_W-1:0] close_tick;
    close_tick = last_tick;
    if (act == ACT_FINISH) begin
      if (open_depth == 0) begin
        queue_result(KIND_BEGIN, '0, '0, ST_NOTHING_OPEN, 1'b1);
      end else begin
        while (open_depth > 0) begin
          open_depth--;
          queue_result(KIND_END, open_fns[open_depth], close_tick, ST_INSERTED,
                       open_depth == 0);
          close_tick += TICK_W'(end_gap);
        end
      end
      open_depth   = 0;
      orphan_depth = 0;
      last_tick    = '0;
    end else if (kind == KIND_BEGIN) begin
      if (orphan_depth > 0 && orphan_fns[orphan_depth-1] == fn) begin
        orphan_depth--;
        queue_result(KIND_BEGIN, fn, tick, ST_BEGIN_DROPPED, 1'b1);
      end else if (open_depth >= STACK_DEPTH) begin
        queue_result(KIND_BEGIN, fn, tick, ST_OVERFLOW, 1'b1);
      end else begin
        open_fns[open_depth] = fn;
        open_depth++;
        last_tick = tick;
        queue_result(KIND_BEGIN, fn, tick, ST_KEPT, 1'b1);
      end
    end else if (open_depth == 0) begin
      if (orphan_depth >= STACK_DEPTH) begin
        queue_result(KIND_END, fn, tick, ST_OVERFLOW, 1'b1);
      end else begin
        orphan_fns[orphan_depth] = fn;
        orphan_depth++;
        queue_result(KIND_END, fn, tick, ST_ORPHAN_DROP, 1'b1);
      end
    end else begin
      open_depth--;
      last_tick = tick;
      queue_result(KIND_END, fn, tick, ST_KEPT, 1'b1);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      repaired_q.delete();
      open_depth    = 0;
      orphan_depth  = 0;
      last_tick     = '0;
      end_gap       = GAP_RESET;
      fail_count    = 0;
      results_seen  = 0;
      inserted_seen = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (repaired_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none pending, status %0d",
                                    results_seen, out_ch.status));
        end else begin
          oldest = repaired_q.pop_front();
          check_field("kind", TICK_W'(out_ch.out_kind), TICK_W'(oldest.kind));
          check_field("function", TICK_W'(out_ch.out_function), TICK_W'(oldest.fn));
          check_field("tick", out_ch.out_tick, oldest.tick);
          check_field("status", TICK_W'(out_ch.status), TICK_W'(oldest.status));
          check_field("last", TICK_W'(out_ch.last), TICK_W'(oldest.last));
          if (oldest.status == ST_INSERTED) begin
            inserted_seen++;
          end
        end
        results_seen++;
      end
      if (psel && penable && pwrite && pready && paddr == GAP_ADDR) begin
        end_gap = pwdata[GAP_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        repair_request(action_t'(in_ch.action), kind_t'(in_ch.event_kind),
                       in_ch.function_index, in_ch.event_tick);
      end
    end
    pending <= repaired_q.size();
  end

endmodule

@@ tb/sv/trace_begin_end_repair_tb.sv @@
// ----------------------------------------------------------------------------
// trace_begin_end_repair_tb: testbench top for the trace begin/end repair block
// Drives profiler events and finish requests with random gaps, stalls the
// result channel at random, and rewrites the inserted end gap between phases.
// A directed part covers the special cases, then nested bursts, orphan
// patterns, stack overflow fills and noise run under four gap settings.
// ----------------------------------------------------------------------------
module trace_begin_end_repair_tb;
  import tber_pkg::*;

  localparam int                HALF_PERIOD   = 10;
  localparam int                CYCLE_LIMIT   = 400000;
  localparam int                SETTLE_CYCLES = 8;
  localparam int                RANDOM_ITEMS  = 130;
  localparam int                PHASES        = 4;
  localparam logic [ADDR_W-1:0] GAP_ADDR      = ADDR_W'(4 * REG_GAP);

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bit                quiet;
  int                cycle_count;
  int                sent_requests;
  int                finishes_sent;
  int                directed_count;
  int                fail_count;
  int                pending;
  int                results_seen;
  int                inserted_seen;
  logic [TICK_W-1:0] event_clock;
  logic [GAP_W-1:0]  gap_plan [PHASES];

  tber_in_if  in_ch ();
  tber_out_if out_ch ();

  trace_begin_end_repair i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  trace_repair_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .inserted_seen (inserted_seen)
  );

  initial clk = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic logic [FN_W-1:0] pick_function();
    if ($urandom_range(0, 3) == 0) begin
      return FN_W'($urandom_range(0, 65535));
    end
    return FN_W'($urandom_range(0, 7));
  endfunction

  task automatic send_request(action_t act, kind_t kind, logic [FN_W-1:0] fn,
                              logic [TICK_W-1:0] tick);
    int idle;
    idle = quiet ? 0 : $urandom_range(0, 15);
    if (idle > 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.event_kind     <= kind;
    in_ch.function_index <= fn;
    in_ch.event_tick     <= tick;
    do @(posedge clk); while (!in_ch.ready);
    sent_requests++;
    if (act == ACT_FINISH) begin
      finishes_sent++;
    end
  endtask

  task automatic send_event(kind_t kind, logic [FN_W-1:0] fn);
    event_clock += TICK_W'($urandom_range(0, 2000));
    send_request(ACT_EVENT, kind, fn, event_clock);
  endtask

  task automatic send_finish();
    send_request(ACT_FINISH, kind_t'($urandom_range(0, 1)), FN_W'($urandom_range(0, 65535)),
                 {$urandom, $urandom});
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gap(logic [GAP_W-1:0] gap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAP_ADDR;
    pwdata  <= {16'($urandom_range(0, 65535)), gap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic fill_open_stack();
    send_finish();
    repeat (STACK_DEPTH + 2) send_event(KIND_BEGIN, FN_W'($urandom_range(0, 65535)));
    send_finish();
  endtask

  task automatic fill_orphan_stack();
    logic [FN_W-1:0] fns [STACK_DEPTH+1];
    send_finish();
    for (int i = 0; i <= STACK_DEPTH; i++) begin
      fns[i] = FN_W'($urandom_range(0, 65535));
      send_event(KIND_END, fns[i]);
    end
    send_event(KIND_BEGIN, fns[STACK_DEPTH-1]);
    send_event(KIND_BEGIN, fns[STACK_DEPTH]);
    send_event(KIND_BEGIN, fns[STACK_DEPTH-2]);
    send_finish();
  endtask

  task automatic nested_burst();
    int depth;
    int closes;
    depth = $urandom_range(1, 8);
    repeat (depth) send_event(KIND_BEGIN, pick_function());
    closes = $urandom_range(0, depth + 2);
    repeat (closes) send_event(KIND_END, pick_function());
  endtask

  task automatic orphan_burst();
    logic [FN_W-1:0] outer;
    logic [FN_W-1:0] inner;
    outer = pick_function();
    inner = pick_function();
    send_finish();
    send_event(KIND_END, outer);
    send_event(KIND_END, inner);
    send_event(KIND_BEGIN, inner);
    send_event(KIND_BEGIN, outer);
    send_event(KIND_BEGIN, pick_function());
  endtask

  task automatic random_step();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: nested_burst();
      5, 6: orphan_burst();
      7: send_request(action_t'($urandom_range(0, 1)), kind_t'($urandom_range(0, 1)),
                      FN_W'($urandom_range(0, 65535)), {$urandom, $urandom});
      8: send_finish();
      default: begin
        send_finish();
        wait_idle();
      end
    endcase
  endtask

  initial begin
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.action         <= ACT_EVENT;
    in_ch.event_kind     <= KIND_BEGIN;
    in_ch.function_index <= '0;
    in_ch.event_tick     <= '0;
    quiet                 = 1'b0;
    cycle_count           = 0;
    sent_requests         = 0;
    finishes_sent         = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Orphan ends, drops of their matching begins, a mismatched end that still
    // pops, and inserted end ticks that wrap past the top of the tick range.
    send_request(ACT_FINISH, KIND_BEGIN, 16'h0000, 64'd0);
    send_request(ACT_EVENT, KIND_END, 16'hFFFF, 64'd0);
    send_request(ACT_EVENT, KIND_END, 16'h0001, 64'd5);
    send_request(ACT_EVENT, KIND_BEGIN, 16'hFFFF, 64'd6);
    send_request(ACT_EVENT, KIND_END, 16'h0000, 64'd7);
    send_request(ACT_EVENT, KIND_BEGIN, 16'h0001, 64'd8);
    send_request(ACT_EVENT, KIND_BEGIN, 16'hFFFF, 64'd9);
    send_request(ACT_EVENT, KIND_BEGIN, 16'h0000, 64'hFFFF_FFFF_FFFF_FFCE);
    send_request(ACT_EVENT, KIND_BEGIN, 16'hA5A5, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_FINISH, KIND_BEGIN, 16'h0000, 64'd0);
    send_request(ACT_EVENT, KIND_END, 16'h5A5A, 64'd0);
    send_request(ACT_FINISH, KIND_END, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_EVENT, KIND_BEGIN, 16'h5A5A, 64'd1);
    send_request(ACT_FINISH, KIND_BEGIN, 16'h0000, 64'd0);
    directed_count = sent_requests;
    wait_idle();

    gap_plan[0] = '0;
    gap_plan[1] = '1;
    gap_plan[2] = GAP_W'($urandom_range(1, 65534));
    gap_plan[3] = GAP_W'(1);
    for (int ph = 0; ph < PHASES; ph++) begin
      write_gap(gap_plan[ph]);
      quiet       = (ph == 2);
      event_clock = {$urandom, $urandom};
      if (ph == 1) begin
        event_clock = {32'hFFFF_FFFF, $urandom};
        fill_open_stack();
      end else if (ph == 3) begin
        fill_orphan_stack();
      end
      while (sent_requests < directed_count + (ph + 1) * RANDOM_ITEMS / PHASES) begin
        random_step();
      end
      send_finish();
      wait_idle();
    end

    $display("Sent %0d requests, %0d of them finishes, under four end gap settings.",
             sent_requests, finishes_sent);
    $display("Compared %0d results, %0d of them inserted ends.", results_seen, inserted_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tber_pkg.sv
rtl/tber_in_if.sv
rtl/tber_out_if.sv
rtl/tber_ctrl.sv
rtl/tber_dp.sv
rtl/trace_begin_end_repair.sv
rtl/tber_chk.sv
tb/sv/trace_repair_checker.sv
tb/sv/trace_begin_end_repair_tb.sv
